// File: design/sga_pkg.sv
// Shared types and request codes for the sparse graph aggregation block.
package sga_pkg;

  // Request codes as they arrive on the input channel.
  localparam logic [1:0] REQ_WR_FEAT = 2'd0;
  localparam logic [1:0] REQ_WR_ACC  = 2'd1;
  localparam logic [1:0] REQ_EDGE    = 2'd2;
  localparam logic [1:0] REQ_READ    = 2'd3;

  // Operations carried from the front end to the back end.
  typedef enum logic [1:0] {
    OP_WR_FEAT = 2'd0,
    OP_WR_ACC  = 2'd1,
    OP_EDGE    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // One classified command; ok marks an in-range read.
  typedef struct packed {
    op_t         op;
    logic        ok;
    logic [9:0]  dst;
    logic [9:0]  src;
    logic [2:0]  lane;
    logic [31:0] data;
    logic [15:0] weight;
  } cmd_t;

  // Back end status seen by the front end.
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

// File: design/sga_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/sga_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module sga_front #(
  parameter int NODES = 1024,
  parameter int LANES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_req_type,
  input  logic [9:0]         in_dst_node,
  input  logic [9:0]         in_src_node,
  input  logic [2:0]         in_lane,
  input  logic signed [31:0] in_data_word,
  input  logic signed [15:0] in_edge_weight,
  input  sga_pkg::back_stat_t stat,
  output logic               busy,
  output logic               cmd_valid,
  output sga_pkg::cmd_t      cmd
);
  import sga_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  cmd_t       cmd_in;
  logic       keep;
  logic       push;
  logic       dst_ok;
  logic       src_ok;
  logic       lane_ok;

  // Range checks against the configured store size.
  assign dst_ok  = 32'(in_dst_node) < NODES;
  assign src_ok  = 32'(in_src_node) < NODES;
  assign lane_ok = 32'(in_lane) < LANES;

  // Classify the request; writes and edges that miss the store are dropped here.
  always_comb begin
    cmd_in.dst    = in_dst_node;
    cmd_in.src    = in_src_node;
    cmd_in.lane   = in_lane;
    cmd_in.data   = in_data_word;
    cmd_in.weight = in_edge_weight;
    cmd_in.ok     = dst_ok && lane_ok;
    case (in_req_type)
      REQ_WR_FEAT: begin
        cmd_in.op = OP_WR_FEAT;
        keep      = dst_ok && lane_ok;
      end
      REQ_WR_ACC: begin
        cmd_in.op = OP_WR_ACC;
        keep      = dst_ok && lane_ok;
      end
      REQ_EDGE: begin
        cmd_in.op = OP_EDGE;
        keep      = dst_ok && src_ok;
      end
      REQ_READ: begin
        cmd_in.op = OP_READ;
        keep      = 1'b1;
      end
      default: begin
        cmd_in.op = OP_READ;
        keep      = 1'b1;
      end
    endcase
  end

  // The block stalls new requests when the queue is full or the store is clearing.
  assign busy      = cnt_r[1] || stat.clearing;
  assign push      = start && !busy && keep;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, stat.pop};

  // Two-entry command queue, control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (stat.pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: design/sga_back.sv
// Back end: executes queued commands against the feature and accumulator stores.
module sga_back #(
  parameter int NODES = 1024,
  parameter int LANES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  sga_pkg::cmd_t      cmd,
  output sga_pkg::back_stat_t stat,
  output logic               out_valid,
  output logic signed [31:0] out_read_data
);
  import sga_pkg::*;

  localparam int DEPTH = NODES * LANES;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;

  typedef enum logic [3:0] {
    B_CLEAR = 4'b0001,
    B_IDLE  = 4'b0010,
    B_EDGE  = 4'b0100,
    B_DRAIN = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0]      lane_cnt_r, lane_cnt_nxt;
  logic [AW-1:0]      dst_base_r, dst_base_nxt;
  logic [AW-1:0]      src_base_r, src_base_nxt;
  logic signed [15:0] weight_r, weight_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               s1_v_r, s1_v_nxt;
  logic [AW-1:0]      s1_addr_r, s1_addr_nxt;
  logic               s2_v_r;
  logic [AW-1:0]      s2_addr_r;
  logic signed [47:0] prod_r;
  logic [31:0]        acc_q_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic          feat_we, feat_re;
  logic [AW-1:0] feat_waddr, feat_raddr;
  logic [31:0]   feat_rdata;
  logic          acc_we, acc_re;
  logic [AW-1:0] acc_waddr, acc_raddr;
  logic [31:0]   acc_wdata, acc_rdata;
  logic [AW-1:0] cmd_addr;
  logic [48:0]   sum;
  logic [31:0]   sum_sat;
  logic          pop;

  // Word address of a write or read command.
  assign cmd_addr = AW'(32'(cmd.dst) * LANES + 32'(cmd.lane));

  // Widened sum of the lane product and the old accumulator word, then saturation.
  assign sum = {prod_r[47], prod_r} + {{17{acc_q_r[31]}}, acc_q_r};
  always_comb begin
    if (!sum[48] && (|sum[47:31])) begin
      sum_sat = 32'h7fff_ffff;
    end else if (sum[48] && !(&sum[47:31])) begin
      sum_sat = 32'h8000_0000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // Sequencer: clearing pass, command dispatch and lane issue for edges.
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    lane_cnt_nxt = lane_cnt_r;
    dst_base_nxt = dst_base_r;
    src_base_nxt = src_base_r;
    weight_nxt   = weight_r;
    rd_pend_nxt  = 1'b0;
    rd_ok_nxt    = rd_ok_r;
    s1_v_nxt     = 1'b0;
    s1_addr_nxt  = s1_addr_r;
    pop          = 1'b0;
    feat_we      = 1'b0;
    feat_waddr   = cmd_addr;
    feat_re      = 1'b0;
    feat_raddr   = src_base_r + AW'(lane_cnt_r);
    acc_we       = 1'b0;
    acc_waddr    = cmd_addr;
    acc_wdata    = cmd.data;
    acc_re       = 1'b0;
    acc_raddr    = cmd_addr;
    case (state_r)
      B_CLEAR: begin
        acc_we      = 1'b1;
        acc_waddr   = clr_cnt_r;
        acc_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (cmd_valid) begin
          pop = 1'b1;
          case (cmd.op)
            OP_WR_FEAT: begin
              feat_we = 1'b1;
            end
            OP_WR_ACC: begin
              acc_we = 1'b1;
            end
            OP_EDGE: begin
              dst_base_nxt = AW'(32'(cmd.dst) * LANES);
              src_base_nxt = AW'(32'(cmd.src) * LANES);
              weight_nxt   = cmd.weight;
              lane_cnt_nxt = '0;
              state_nxt    = B_EDGE;
            end
            OP_READ: begin
              acc_re      = 1'b1;
              rd_pend_nxt = 1'b1;
              rd_ok_nxt   = cmd.ok;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_EDGE: begin
        feat_re      = 1'b1;
        acc_re       = 1'b1;
        acc_raddr    = dst_base_r + AW'(lane_cnt_r);
        s1_v_nxt     = 1'b1;
        s1_addr_nxt  = dst_base_r + AW'(lane_cnt_r);
        lane_cnt_nxt = lane_cnt_r + LW'(1);
        if (lane_cnt_r == LW'(LANES - 1)) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    // Lane write-back from the last pipeline stage.
    if (s2_v_r) begin
      acc_we    = 1'b1;
      acc_waddr = s2_addr_r;
      acc_wdata = sum_sat;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s1_v_r;
      out_valid_r <= rd_pend_r;
    end
  end

  // Datapath registers: edge context, multiply stage and read result.
  always_ff @(posedge clk) begin
    lane_cnt_r <= lane_cnt_nxt;
    dst_base_r <= dst_base_nxt;
    src_base_r <= src_base_nxt;
    weight_r   <= weight_nxt;
    rd_ok_r    <= rd_ok_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s2_addr_r  <= s1_addr_r;
    prod_r     <= $signed(feat_rdata) * weight_r;
    acc_q_r    <= acc_rdata;
    out_data_r <= rd_ok_r ? acc_rdata : 32'd0;
  end

  sga_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_feat_ram (
    .clk   (clk),
    .we    (feat_we),
    .waddr (feat_waddr),
    .wdata (cmd.data),
    .re    (feat_re),
    .raddr (feat_raddr),
    .rdata (feat_rdata)
  );

  sga_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  assign stat.clearing = state_r == B_CLEAR;
  assign stat.pop      = pop;
  assign out_valid     = out_valid_r;
  assign out_read_data = $signed(out_data_r);

endmodule

// File: design/sparse_graph_aggregation.sv
// Top level of the sparse graph aggregation block.
//
// A request is taken at a rising edge where start is high and busy is low.
// Request types: write a feature word, write an accumulator word, an edge
// (for every lane, acc[dst][lane] += feat[src][lane] * weight, saturating),
// or read one accumulator word. Only a read gives a result: out_read_data
// is shown for exactly one cycle with out_valid high; it cannot be held off.
// Requests pass through a two-entry queue, so after the clearing pass busy
// rises only when the queue is full. A write is done in its dispatch cycle.
// A read result passes the memory read register and the result register.
// An edge takes the dispatch cycle, one lane per cycle through the shared
// multiply-accumulate and the single accumulator memory write port, and a
// drain while the last lane passes through the write-back pipeline. At the
// earliest, out_valid rises once a taken read request has passed the queue,
// the memory read register and the result register. After reset, every
// accumulator word is cleared, one word per cycle, while busy stays high.
// Feature words are undefined until written.
module sparse_graph_aggregation #(
  parameter int NODES = 1024,
  parameter int LANES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [9:0]         in_dst_node,
  input  logic [9:0]         in_src_node,
  input  logic [2:0]         in_lane,
  input  logic signed [31:0] in_data_word,
  input  logic signed [15:0] in_edge_weight,
  output logic               out_valid,
  output logic signed [31:0] out_read_data
);
  import sga_pkg::*;

  back_stat_t stat;
  logic       cmd_valid;
  cmd_t       cmd;

  // Front end with request queue.
  sga_front #(.NODES(NODES), .LANES(LANES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_req_type    (in_req_type),
    .in_dst_node    (in_dst_node),
    .in_src_node    (in_src_node),
    .in_lane        (in_lane),
    .in_data_word   (in_data_word),
    .in_edge_weight (in_edge_weight),
    .stat           (stat),
    .busy           (busy),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd)
  );

  // Back end with the two stores.
  sga_back #(.NODES(NODES), .LANES(LANES)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_read_data (out_read_data)
  );

endmodule

// File: design/sga_checker.sv
// Port-level checks for the sparse graph aggregation block, bound to the top level.
module sga_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid
);

  // Reset leaves no result pending.
  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // The clearing pass holds off requests as soon as reset is released.
  a_busy_after_reset: assert property (@(posedge clk) rst_n && $past(!rst_n) |-> busy)
    else $error("block not busy while clearing after reset");

  // A result cannot appear right after reset is released.
  a_result_needs_time: assert property (@(posedge clk)
    out_valid |-> $past(rst_n, 1) && $past(rst_n, 2))
    else $error("result strobe too soon after reset");

endmodule

bind sparse_graph_aggregation sga_checker u_sga_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid)
);
